>>> hdl/nll_pkg.sv
`default_nettype none

package nll_pkg;

    // Word and datapath widths
    localparam int SAMPLE_W      = 16;
    localparam int STAGE_W       = 24;  // Q2.22 stage values
    localparam int STAGE_SUM_W   = STAGE_W + 2;
    localparam int ARG_W         = 28;  // widest tanh argument
    localparam int TANH_W        = 23;  // unsigned table entries, Q.22
    localparam int TANH_SPAN_LOG2 = 24; // table spans [0, 4) in Q.22
    localparam int MUL_A_W       = 17;
    localparam int MUL_B_W       = 25;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int OUT_WIDE_W    = STAGE_W - 7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CUTOFF_W   = 16;
    localparam int RES_W      = 15;
    localparam int DRIVE_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE     = 2'd2;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd15166;
    localparam logic [RES_W-1:0]    RES_RESET    = 15'd4096;
    localparam logic [DRIVE_W-1:0]  DRIVE_RESET  = 16'd4506;
    localparam logic [RES_W-1:0]    RES_MAX      = 15'd20480;
    localparam logic [DRIVE_W-1:0]  DRIVE_MIN    = 16'd410;
    localparam logic [DRIVE_W-1:0]  DRIVE_MAX    = 16'd40960;

    localparam logic signed [STAGE_SUM_W-1:0] STAGE_MAX = 26'sd8388607;
    localparam logic signed [STAGE_SUM_W-1:0] STAGE_MIN = -26'sd8388608;
    localparam logic signed [OUT_WIDE_W-1:0]  OUT_MAX   = 17'sd32767;
    localparam logic signed [OUT_WIDE_W-1:0]  OUT_MIN   = -17'sd32768;

    // Microcode
    typedef enum logic [1:0] {MUL_NONE, MUL_DRIVE, MUL_RES, MUL_CUT} mul_op_t;
    typedef enum logic [1:0] {ARG_NONE, ARG_DRIVE, ARG_FB, ARG_STAGE} arg_op_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_DRIVEN, CAP_TIN, CAP_TS} cap_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_DONE} seq_op_t;

    localparam int STEP_W    = 6;
    localparam int N_STEPS   = 39;
    localparam int STEP_PASS = 6;

    typedef struct packed {
        mul_op_t           mul;
        arg_op_t           arg;
        cap_op_t           cap;
        logic              wr;
        logic [1:0]        sel;
        seq_op_t           seq;
        logic [STEP_W-1:0] target;
    } ucode_t;

    localparam ucode_t UCODE_NOP = '{
        mul: MUL_NONE, arg: ARG_NONE, cap: CAP_NONE, wr: 1'b0,
        sel: 2'd0, seq: SEQ_NEXT, target: '0
    };

    // Program: drive lookup, then one pass per oversample step. Each pass
    // looks up tanh of the feedback input and of each stage, then moves the
    // stages in order. A tanh result passes the argument register and three pipeline registers before it is captured.
    function automatic ucode_t ucode_at(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = UCODE_NOP;
        unique case (step)
            0:  w.mul = MUL_DRIVE;
            1:  w.arg = ARG_DRIVE;
            5:  w.cap = CAP_DRIVEN;
            6:  begin
                    w.mul = MUL_RES;
                    w.arg = ARG_STAGE;
                    w.sel = 2'd0;
                end
            7:  w.arg = ARG_FB;
            10: w.cap = CAP_TS;
            11: w.cap = CAP_TIN;
            12: w.mul = MUL_CUT;
            13: begin
                    w.wr  = 1'b1;
                    w.sel = 2'd0;
                end
            14: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd0;
                end
            15: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd1;
                end
            18: w.cap = CAP_TIN;
            19: w.cap = CAP_TS;
            20: w.mul = MUL_CUT;
            21: begin
                    w.wr  = 1'b1;
                    w.sel = 2'd1;
                end
            22: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd1;
                end
            23: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd2;
                end
            26: w.cap = CAP_TIN;
            27: w.cap = CAP_TS;
            28: w.mul = MUL_CUT;
            29: begin
                    w.wr  = 1'b1;
                    w.sel = 2'd2;
                end
            30: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd2;
                end
            31: begin
                    w.arg = ARG_STAGE;
                    w.sel = 2'd3;
                end
            34: w.cap = CAP_TIN;
            35: w.cap = CAP_TS;
            36: w.mul = MUL_CUT;
            37: begin
                    w.wr     = 1'b1;
                    w.sel    = 2'd3;
                    w.seq    = SEQ_LOOP;
                    w.target = STEP_W'(STEP_PASS);
                end
            38: w.seq = SEQ_DONE;
            default: w = UCODE_NOP;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/nonlinear_ladder_lowpass.sv
// Nonlinear four-pole ladder low-pass with resonance, oversampled OVERSAMPLE
// times per word. Each sample_in word is scaled by the clamped drive, passed
// through tanh, and then drives OVERSAMPLE passes of four tanh-coupled
// one-pole stages; the first stage sees the drive minus resonance times the
// average of the last stage's current and previous values. sample_out is the
// last stage floored to Q1.15 and saturated. Registers: index 0 cutoff_gain
// (Q0.16), 1 resonance_amount (Q3.12, used as at most 5.0), 2 drive_gain
// (Q4.12, used within 0.1 to 10); other indexes are ignored, and writes are
// meant for idle periods only. One word is in flight at a time: after a word
// is accepted the block stays busy until its final step, which holds as long
// as a previous word still waits in the output register, so in_ready stays
// low until the word has run all OVERSAMPLE passes. The pace is set by the
// stage chain of each pass: every stage waits for tanh of the stage before
// it, through the table pipeline, plus one multiply and one update. A
// finished word waits in the output register while the next word is already
// accepted. The tanh table holds TANH_TABLE_DEPTH+1 points over [0, 4] and
// is a ROM built at elaboration.
`default_nettype none

module nonlinear_ladder_lowpass #(
    parameter int OVERSAMPLE       = 2,
    parameter int TANH_TABLE_DEPTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [nll_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [nll_pkg::SAMPLE_W-1:0]       sample_out,
    input  wire logic                                 cfg_write,
    input  wire logic [nll_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [nll_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import nll_pkg::*;

    localparam int PASS_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(OVERSAMPLE - 1);
    localparam int D_W    = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int P_W    = TANH_SPAN_LOG2 + D_W;
    localparam int LERP_W = TANH_W + TANH_SPAN_LOG2;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef longint unsigned u64_t;
    typedef logic [TANH_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH+1];

    // Restoring long division, used only while the table is built
    function automatic u64_t udiv_u64(input u64_t num, input u64_t den);
        u64_t q;
        u64_t rem;
        int   i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4k/D) in Q.22 from e^{-8k/D} = (e^{-k/D})^8, series in Q30
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t rom;
        u64_t      a;
        u64_t      mag;
        u64_t      e;
        longint    sum;
        int        k;
        int        n;
        for (k = 0; k <= TANH_TABLE_DEPTH; k++)
        begin
            a   = udiv_u64(u64_t'(k) << 30, u64_t'(TANH_TABLE_DEPTH));
            mag = ONE_Q30;
            sum = longint'(ONE_Q30);
            for (n = 1; n <= 24; n++)
            begin
                mag = udiv_u64((mag * a) >> 30, u64_t'(n));
                if ((n & 1) != 0) sum = sum - longint'(mag);
                else              sum = sum + longint'(mag);
            end
            if (sum < 0) sum = 0;
            e = u64_t'(sum);
            for (n = 0; n < 3; n++) e = (e * e) >> 30;
            rom[k] = TANH_W'(udiv_u64((ONE_Q30 - e) << 22, ONE_Q30 + e));
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();
    localparam logic [TANH_W-1:0] TANH_END = TANH_ROM[TANH_TABLE_DEPTH];

    // Configuration registers
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [RES_W-1:0]    res_reg;
    logic [DRIVE_W-1:0]  drive_reg;
    logic [RES_W-1:0]    res_eff;
    logic [DRIVE_W-1:0]  drive_eff;

    // Sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_fire;
    logic              slot_free;
    logic              done_fire;
    ucode_t            uw;

    // Datapath
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [SAMPLE_W-1:0]  out_reg;
    logic signed [STAGE_W-1:0]   stage_reg [4];
    logic signed [STAGE_W-1:0]   stage_prev_reg;
    logic signed [STAGE_W-1:0]   driven_reg;
    logic signed [STAGE_W-1:0]   tin_reg;
    logic signed [STAGE_W-1:0]   ts_reg;
    logic signed [ARG_W-1:0]     tanh_arg_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [ARG_W-1:0]     arg_next;
    logic signed [ARG_W-1:0]     fb;
    logic signed [STAGE_W:0]     tail_sum;
    logic signed [STAGE_W-1:0]   tail_avg;
    logic signed [STAGE_W-1:0]   stage_cur;
    logic signed [STAGE_SUM_W-1:0] stage_sum;
    logic signed [STAGE_W-1:0]   stage_next;
    logic signed [OUT_WIDE_W-1:0] y_wide;
    logic signed [SAMPLE_W-1:0]  y_next;

    // tanh pipeline
    logic                       t1_neg_reg, t1_big_reg;
    logic [P_W-1:0]             t1_p_reg;
    logic                       t2_neg_reg, t2_big_reg;
    logic [TANH_SPAN_LOG2-1:0]  t2_frac_reg;
    logic [TANH_W-1:0]          t2_lo_reg, t2_hi_reg;
    logic                       t3_neg_reg, t3_big_reg;
    logic [TANH_W-1:0]          t3_lo_reg;
    logic [LERP_W-1:0]          t3_prod_reg;
    logic                       arg_neg;
    logic [ARG_W-1:0]           arg_mag;
    logic [D_W-1:0]             rom_idx;
    logic [D_W-1:0]             rom_idx_hi;
    logic [TANH_W-1:0]          rom_diff;
    logic [TANH_W-1:0]          tanh_mag;
    logic signed [STAGE_W-1:0]  tanh_res;

    assign in_ready   = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // Clamp the registers to their working range
    always_comb
    begin
        res_eff = (res_reg > RES_MAX) ? RES_MAX : res_reg;
        if (drive_reg < DRIVE_MIN)
            drive_eff = DRIVE_MIN;
        else if (drive_reg > DRIVE_MAX)
            drive_eff = DRIVE_MAX;
        else
            drive_eff = drive_reg;
    end

    // Sequencer: step counter, pass counter and the output slot
    always_comb
    begin
        uw        = ucode_at(step_reg);
        in_fire   = in_valid && !busy_reg;
        slot_free = !out_valid_reg || out_ready;
        done_fire = busy_reg && (uw.seq == SEQ_DONE) && slot_free;

        step_next = step_reg;
        pass_next = pass_reg;
        busy_next = busy_reg;
        if (in_fire)
        begin
            step_next = '0;
            pass_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            unique case (uw.seq)
                SEQ_NEXT: step_next = step_reg + 1'b1;
                SEQ_LOOP:
                begin
                    // take another pass until the last one is done
                    if (pass_reg != PASS_LAST)
                    begin
                        pass_next = pass_reg + 1'b1;
                        step_next = uw.target;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                SEQ_DONE:
                begin
                    // hold here until the output register is free
                    if (slot_free)
                        busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (done_fire)
            out_valid_next = 1'b1;
    end

    // Shared multiplier operands, tanh argument and stage update
    always_comb
    begin
        tail_sum  = (STAGE_W+1)'(stage_reg[3]) + (STAGE_W+1)'(stage_prev_reg);
        tail_avg  = STAGE_W'(tail_sum >>> 1);
        fb        = ARG_W'(prod_reg >>> 12);
        stage_cur = stage_reg[uw.sel];
        stage_sum = STAGE_SUM_W'(stage_cur) + STAGE_SUM_W'(prod_reg >>> 16);
        if (stage_sum > STAGE_MAX)
            stage_next = STAGE_W'(STAGE_MAX);
        else if (stage_sum < STAGE_MIN)
            stage_next = STAGE_W'(STAGE_MIN);
        else
            stage_next = STAGE_W'(stage_sum);

        unique case (uw.mul)
            MUL_DRIVE:
            begin
                mul_a = MUL_A_W'(drive_eff);
                mul_b = MUL_B_W'(x_reg);
            end
            MUL_RES:
            begin
                mul_a = MUL_A_W'(res_eff);
                mul_b = MUL_B_W'(tail_avg);
            end
            MUL_CUT:
            begin
                mul_a = MUL_A_W'(cutoff_reg);
                mul_b = MUL_B_W'(tin_reg) - MUL_B_W'(ts_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        unique case (uw.arg)
            ARG_DRIVE: arg_next = ARG_W'(prod_reg >>> 5);
            ARG_FB:    arg_next = ARG_W'(driven_reg) - fb;
            ARG_STAGE: arg_next = ARG_W'(stage_cur);
            default:   arg_next = tanh_arg_reg;
        endcase

        y_wide = OUT_WIDE_W'(stage_reg[3] >>> 7);
        if (y_wide > OUT_MAX)
            y_next = SAMPLE_W'(OUT_MAX);
        else if (y_wide < OUT_MIN)
            y_next = SAMPLE_W'(OUT_MIN);
        else
            y_next = SAMPLE_W'(y_wide);
    end

    // tanh combinational parts: magnitude, table index, difference, and the saturated, signed result
    always_comb
    begin
        arg_neg    = tanh_arg_reg[ARG_W-1];
        arg_mag    = arg_neg ? ARG_W'(-tanh_arg_reg) : ARG_W'(tanh_arg_reg);
        rom_idx    = t1_p_reg[P_W-1:TANH_SPAN_LOG2];
        rom_idx_hi = rom_idx + 1'b1;
        rom_diff   = t2_hi_reg - t2_lo_reg;
        tanh_mag   = t3_big_reg ? TANH_END
                   : t3_lo_reg + t3_prod_reg[LERP_W-1:TANH_SPAN_LOG2];
        tanh_res   = t3_neg_reg ? -STAGE_W'(tanh_mag) : STAGE_W'(tanh_mag);
    end

    // tanh pipeline: position, table read, interpolation product
    always_ff @(posedge clk)
    begin
        t1_neg_reg  <= arg_neg;
        t1_big_reg  <= |arg_mag[ARG_W-1:TANH_SPAN_LOG2];
        t1_p_reg    <= P_W'(arg_mag[TANH_SPAN_LOG2-1:0]) * P_W'(TANH_TABLE_DEPTH);

        t2_neg_reg  <= t1_neg_reg;
        t2_big_reg  <= t1_big_reg;
        t2_frac_reg <= t1_p_reg[TANH_SPAN_LOG2-1:0];
        t2_lo_reg   <= TANH_ROM[rom_idx];
        t2_hi_reg   <= TANH_ROM[rom_idx_hi];

        t3_neg_reg  <= t2_neg_reg;
        t3_big_reg  <= t2_big_reg;
        t3_lo_reg   <= t2_lo_reg;
        t3_prod_reg <= LERP_W'(rom_diff) * LERP_W'(t2_frac_reg);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            x_reg <= sample_in;
        if (done_fire)
            out_reg <= y_next;
        if (busy_reg)
        begin
            if (uw.mul != MUL_NONE)
                prod_reg <= mul_a * mul_b;
            tanh_arg_reg <= arg_next;
            unique case (uw.cap)
                CAP_DRIVEN: driven_reg <= tanh_res;
                CAP_TIN:    tin_reg    <= tanh_res;
                CAP_TS:     ts_reg     <= tanh_res;
                default:    ;
            endcase
        end
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            pass_reg       <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            cutoff_reg     <= CUTOFF_RESET;
            res_reg        <= RES_RESET;
            drive_reg      <= DRIVE_RESET;
            stage_reg[0]   <= '0;
            stage_reg[1]   <= '0;
            stage_reg[2]   <= '0;
            stage_reg[3]   <= '0;
            stage_prev_reg <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            pass_reg      <= pass_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CUTOFF:    cutoff_reg <= cfg_data[CUTOFF_W-1:0];
                    CFG_RESONANCE: res_reg    <= cfg_data[RES_W-1:0];
                    CFG_DRIVE:     drive_reg  <= cfg_data[DRIVE_W-1:0];
                    default:       ;
                endcase
            end

            // move one stage; keep the old last stage for the feedback average
            if (busy_reg && uw.wr)
            begin
                stage_reg[uw.sel] <= stage_next;
                if (uw.sel == 2'd3)
                    stage_prev_reg <= stage_reg[3];
            end
        end
    end

    a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(in_valid && in_ready))
        else $error("sequencer started without an accepted word");

    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg < STEP_W'(N_STEPS)))
        else $error("step counter ran past the program");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= PASS_LAST)
        else $error("pass counter exceeded the oversample count");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire |=> (!busy_reg && out_valid))
        else $error("finished word did not reach the output register");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_fire))
        else $error("output became valid outside the final step");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import nll_pkg::*;

    localparam int OVERSAMPLE       = 2;
    localparam int TANH_POINTS      = 1024;
    localparam int WORD_CYCLES      = 8 + 32 * OVERSAMPLE;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint ONE_Q30      = 64'sd1073741824;

    typedef longint unsigned u64_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block ports; the inputs are all known from time zero
    logic                         in_valid   = 1'b0;
    logic                         in_ready;
    logic signed [SAMPLE_W-1:0]   sample_in  = '0;
    logic                         out_valid;
    logic                         out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample_out;
    logic                         cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index  = '0;
    logic [CFG_DATA_W-1:0]        cfg_data   = '0;

    nonlinear_ladder_lowpass #(
        .OVERSAMPLE       (OVERSAMPLE),
        .TANH_TABLE_DEPTH (TANH_POINTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Ladder predictor: own copy of registers, stage state and tanh table
    // ------------------------------------------------------------------
    logic [CUTOFF_W-1:0] cutoff_q;
    logic [RES_W-1:0]    resonance_q;
    logic [DRIVE_W-1:0]  drive_q;
    longint              pole_one, pole_two, pole_three, pole_four, pole_four_prev;
    longint              tanh_points [0:TANH_POINTS];

    // Fill the tanh table: e^-x from its series up to the 24th-power term, raised to the 8th power,
    // then tanh = (1 - e) / (1 + e), all in integer arithmetic.
    function automatic void fill_tanh_points();
        u64_t   a;
        u64_t   mag;
        longint sum;
        u64_t   e;
        for (int k = 0; k <= TANH_POINTS; k++)
        begin
            a   = (u64_t'(k) << 30) / u64_t'(TANH_POINTS);
            mag = u64_t'(ONE_Q30);
            sum = ONE_Q30;
            for (int n = 1; n <= 24; n++)
            begin
                mag = ((mag * a) >> 30) / u64_t'(n);
                if (n % 2 == 1)
                    sum = sum - longint'(mag);
                else
                    sum = sum + longint'(mag);
            end
            if (sum < 0)
                sum = 0;
            e = u64_t'(sum);
            for (int n = 0; n < 3; n++)
                e = (e * e) >> 30;
            tanh_points[k] = longint'(((u64_t'(ONE_Q30) - e) << 22) / (u64_t'(ONE_Q30) + e));
        end
    endfunction

    // Interpolated, odd-symmetric tanh in Q.22; saturates beyond 4.0
    function automatic longint tanh_q22(input longint v);
        u64_t   m;
        u64_t   p;
        u64_t   idx;
        u64_t   frac;
        longint lo;
        longint hi;
        longint r;
        m = (v < 0) ? u64_t'(-v) : u64_t'(v);
        if (m >= (u64_t'(1) << TANH_SPAN_LOG2))
            r = tanh_points[TANH_POINTS];
        else
        begin
            p    = m * u64_t'(TANH_POINTS);
            idx  = p >> TANH_SPAN_LOG2;
            frac = p & ((u64_t'(1) << TANH_SPAN_LOG2) - 1);
            lo   = tanh_points[idx];
            hi   = tanh_points[idx + 1];
            r    = lo + longint'((u64_t'(hi - lo) * frac) >> TANH_SPAN_LOG2);
        end
        return (v < 0) ? -r : r;
    endfunction

    // One pole: move toward the driving value by g times the tanh difference
    function automatic longint move_pole(input longint s, input longint drive_in,
                                         input longint g);
        longint v;
        v = s + ((g * (drive_in - tanh_q22(s))) >>> 16);
        if (v > longint'(STAGE_MAX))
            v = longint'(STAGE_MAX);
        if (v < longint'(STAGE_MIN))
            v = longint'(STAGE_MIN);
        return v;
    endfunction

    // Advance the ladder by one input word and return the filtered sample
    function automatic logic signed [SAMPLE_W-1:0] filter_word(
        input logic signed [SAMPLE_W-1:0] x_in);
        longint x;
        longint d;
        longint r;
        longint g;
        longint driven;
        longint avg;
        longint fb;
        longint y;
        x = x_in;
        d = longint'(drive_q);
        r = longint'(resonance_q);
        g = longint'(cutoff_q);
        // clamp drive to 0.1..10 and resonance to at most 5.0
        if (d < longint'(DRIVE_MIN))
            d = longint'(DRIVE_MIN);
        if (d > longint'(DRIVE_MAX))
            d = longint'(DRIVE_MAX);
        if (r > longint'(RES_MAX))
            r = longint'(RES_MAX);
        driven = tanh_q22((x * d) >>> 5);
        for (int pass = 0; pass < OVERSAMPLE; pass++)
        begin
            avg            = (pole_four + pole_four_prev) >>> 1;
            fb             = (r * avg) >>> 12;
            pole_one       = move_pole(pole_one, tanh_q22(driven - fb), g);
            pole_two       = move_pole(pole_two, tanh_q22(pole_one), g);
            pole_three     = move_pole(pole_three, tanh_q22(pole_two), g);
            pole_four_prev = pole_four;
            pole_four      = move_pole(pole_four, tanh_q22(pole_three), g);
        end
        y = pole_four >>> 7;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return SAMPLE_W'(y);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and expectation stores
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                         error_count    = 0;
    bit                         sample_taken   = 1'b0;
    bit                         sender_idles   = 1'b0;
    bit                         receiver_idles = 1'b0;
    int                         send_gap       = 0;
    int                         recv_gap       = 0;

    // Driver: hold the word until it is taken, then present the next one or,
    // while sender idling is on, drop valid for a gap counted down in send_gap.
    always @(negedge clk)
    begin
        if (in_valid && !sample_taken)
        begin
            // hold: word still waiting for ready
        end
        else if (send_gap > 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_samples.size() > 0)
        begin
            if (sender_idles && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 12);
            end
            else
            begin
                in_valid  <= 1'b1;
                sample_in <= pending_samples.pop_front();
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Receiver: stall ready in bursts counted down in recv_gap while idling is on
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            out_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
        end
        else if (receiver_idles && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            recv_gap  <= $urandom_range(0, 12);
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: predict on every accepted input word, check every accepted
    // output word against the oldest prediction.
    always @(posedge clk)
    begin
        sample_taken = rst_n && in_valid && in_ready;
        if (sample_taken)
            expected_samples.push_back(filter_word(sample_in));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected word %0d", sample_out);
                error_count++;
            end
            else if (sample_out !== expected_samples[0])
            begin
                $error("sample_out mismatch: expected %0d, actual %0d",
                       expected_samples[0], sample_out);
                error_count++;
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // Write one register and mirror it into the predictor; idle only
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_CUTOFF:    cutoff_q    = value[CUTOFF_W-1:0];
            CFG_RESONANCE: resonance_q = value[RES_W-1:0];
            CFG_DRIVE:     drive_q     = value[DRIVE_W-1:0];
            default:       ;
        endcase
    endtask

    // Wait until every queued word is sent and every result has come back,
    // then let the block settle before returning.
    task automatic wait_for_idle();
        while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (WORD_CYCLES) @(negedge clk);
    endtask

    // Random sample: full range, extremes, small values, or a random walk
    logic signed [SAMPLE_W-1:0] walk_sample = '0;

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int step;
        int next;
        case ($urandom_range(0, 9))
            0, 1, 2: return SAMPLE_W'($urandom);
            3:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            4:       return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            default:
            begin
                step = int'($urandom_range(0, 8192)) - 4096;
                next = int'(walk_sample) + step;
                if (next > 32767)
                    next = 32767;
                if (next < -32768)
                    next = -32768;
                walk_sample = SAMPLE_W'(next);
                return walk_sample;
            end
        endcase
    endfunction

    // Random register settings, extremes mixed in
    task automatic randomize_registers();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = 16'hffff;
            default: v = CFG_DATA_W'($urandom);
        endcase
        write_register(CFG_CUTOFF, v);
        // resonance: mostly in range, sometimes any 16 bits (upper bit dropped)
        if ($urandom_range(0, 3) == 0)
            v = CFG_DATA_W'($urandom);
        else
            v = CFG_DATA_W'($urandom_range(0, RES_MAX));
        write_register(CFG_RESONANCE, v);
        // drive: mostly in range, sometimes outside so the clamp acts
        if ($urandom_range(0, 3) == 0)
            v = CFG_DATA_W'($urandom);
        else
            v = CFG_DATA_W'($urandom_range(DRIVE_MIN, DRIVE_MAX));
        write_register(CFG_DRIVE, v);
        if ($urandom_range(0, 4) == 0)
            write_register(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        fill_tanh_points();
        cutoff_q       = CUTOFF_RESET;
        resonance_q    = RES_RESET;
        drive_q        = DRIVE_RESET;
        pole_one       = 0;
        pole_two       = 0;
        pole_three     = 0;
        pole_four      = 0;
        pole_four_prev = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extremes and bit patterns of the sample
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh0001);
        pending_samples.push_back(16'shffff);
        pending_samples.push_back(16'sh5555);
        pending_samples.push_back(16'shaaaa);
        pending_samples.push_back(16'sh0000);
        wait_for_idle();

        // Directed: everything at the top, resonance and drive past their clamps
        write_register(CFG_CUTOFF, 16'hffff);
        write_register(CFG_RESONANCE, 16'hffff);
        write_register(CFG_DRIVE, 16'hffff);
        for (int i = 0; i < 4; i++)
        begin
            pending_samples.push_back(16'sh7fff);
            pending_samples.push_back(16'sh8000);
        end
        wait_for_idle();

        // Directed: cutoff zero freezes the stages; resonance zero, drive
        // below its floor; an unused index must change nothing
        write_register(CFG_CUTOFF, 16'h0000);
        write_register(CFG_RESONANCE, 16'h0000);
        write_register(CFG_DRIVE, 16'h0000);
        write_register(CFG_UNUSED, 16'hffff);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh8000);
        wait_for_idle();

        // Directed: values just past the clamp edges of resonance and drive
        write_register(CFG_CUTOFF, CUTOFF_RESET);
        write_register(CFG_RESONANCE, CFG_DATA_W'(RES_MAX) + 16'd1);
        write_register(CFG_DRIVE, DRIVE_MIN - 16'd1);
        pending_samples.push_back(16'sh7fff);
        pending_samples.push_back(16'sh4000);
        wait_for_idle();
        write_register(CFG_DRIVE, DRIVE_MAX + 16'd1);
        pending_samples.push_back(16'shc000);
        pending_samples.push_back(16'sh0000);
        wait_for_idle();

        // Random phases; each drain between them also pauses the sender
        // until every expected word has come back.
        for (int phase = 0; phase < 12; phase++)
        begin
            randomize_registers();
            mode           = $urandom_range(0, 3);
            sender_idles   = mode[0];
            receiver_idles = mode[1];
            for (int i = 0; i < 110; i++)
                pending_samples.push_back(pick_sample());
            wait_for_idle();
        end

        // Last part: full rate, no idling on either side
        randomize_registers();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < 180; i++)
            pending_samples.push_back(pick_sample());
        wait_for_idle();
        repeat (WORD_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_samples.size() == 0)
            $display("** nonlinear_ladder_lowpass: PASSED **");
        else
            $display("** nonlinear_ladder_lowpass: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("** nonlinear_ladder_lowpass: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
hdl/nll_pkg.sv
hdl/nonlinear_ladder_lowpass.sv
bench/testbench.sv
